/* hdl/ksm_pkg.sv */
// Shared types and constants for the kernel weighted point smoother.
// Used by ksm_kernel and kernel_weighted_point_smoother_top; no dependencies.
`timescale 1ns / 1ps

package ksm_pkg;

  localparam int MAX_POINTS_DEF = 64;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd2;

  localparam logic [31:0] SMOOTH_LEN_RST = 32'd0;
  localparam logic [31:0] MIN_LEN_RST    = 32'd65536;
  localparam logic [15:0] RADIUS_RST     = 16'd256;

  localparam int W_W    = 17;  // kernel weight, Q1.16 up to 1.0
  localparam int H_W    = 48;  // kernel radius, Q24.24
  localparam int DIFF_W = 33;  // absolute coordinate difference
  localparam logic [W_W-1:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] sample;
    logic               final_point;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         point_index;
    logic signed [31:0] smoothed;
    logic               no_weight;
    logic               run_end;
  } out_item_t;

  // Pair request to the kernel unit
  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] ux;
    logic [DIFF_W-1:0] uy;
  } kreq_t;

  // Kernel unit answer
  typedef struct packed {
    logic           done;
    logic [W_W-1:0] weight;
  } kres_t;

endpackage

/* hdl/kernel_weighted_point_smoother_top.sv */
// Kernel weighted point smoother, top level: point memory, pair sequencer,
// accumulation and final rounding divider. Uses ksm_pkg and ksm_kernel.
`timescale 1ns / 1ps
//
// Usage:
//  - in_data carries one point (pos_x, pos_y, sample, final_point). Items are
//    stored in order, up to MAX_POINTS; further points are dropped.
//  - An item with final_point = 1 closes the set and starts the run; in_ready
//    stays low until the last result of the run has been loaded into the
//    result register.
//  - For each stored point one out_data item follows, in load order; run_end
//    marks the last one. no_weight flags an empty weight sum (smoothed = 0).
//  - Each point pair runs through the kernel unit, where the square root and
//    the division dominate; a pair out of reach skips the division. One result
//    runs all N pairs for N points and then the final divider.
//  - cfg_ready is always high; write registers only while no run is active.
//  - A stalled receiver holds the result register; the sequencer then waits
//    before issuing the next result.
//  - Reset (rst_n low, synchronous) empties the set and restores register
//    defaults; the point memory needs no clearing.

module kernel_weighted_point_smoother_top import ksm_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DEN_W  = W_W + IDX_W;
  localparam int NUM_W  = 50 + IDX_W;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_RDI, S_LATI, S_RDJ, S_LATJ, S_KWAIT, S_MUL, S_ACC, S_DPREP, S_DIV, S_OUT
  } state_t;

  state_t st_r;

  // Configuration registers
  logic [31:0] smooth_len_r, min_len_r;
  logic [15:0] radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_len_r <= SMOOTH_LEN_RST;
      min_len_r    <= MIN_LEN_RST;
      radius_r     <= RADIUS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SMOOTH_LEN: smooth_len_r <= cfg_data;
        CFG_MIN_LEN:    min_len_r    <= cfg_data;
        CFG_RADIUS:     radius_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Point memory: x, y, sample per entry
  logic [95:0]      mem [MAX_POINTS];
  logic [95:0]      rd_q_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [CNT_W-1:0] cnt_r, n_r;
  logic [IDX_W-1:0] i_r, j_r, last_idx;

  assign in_ready = (st_r == S_LOAD);
  assign mem_we   = in_valid && in_ready && (cnt_r < CNT_W'(MAX_POINTS));
  assign rd_addr  = (st_r == S_RDI) ? i_r : j_r;
  assign last_idx = IDX_W'(n_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt_r[IDX_W-1:0]] <= {in_data.pos_x, in_data.pos_y, in_data.sample};
    rd_q_r <= mem[rd_addr];
  end

  // Kernel unit
  kreq_t          kreq;
  kres_t          kres;
  logic [H_W-1:0] h_r;
  logic signed [31:0] xi_r, yi_r, vj_r;
  logic signed [32:0] dx, dy;

  assign dx = 33'(signed'(xi_r)) - 33'(signed'(rd_q_r[95:64]));
  assign dy = 33'(signed'(yi_r)) - 33'(signed'(rd_q_r[63:32]));
  assign kreq.start = (st_r == S_LATJ);
  assign kreq.ux    = dx[32] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign kreq.uy    = dy[32] ? DIFF_W'(-dy) : DIFF_W'(dy);

  ksm_kernel u_kernel (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (kreq),
    .h     (h_r),
    .res   (kres)
  );

  // Accumulation and final division
  logic [W_W-1:0]          w_r;
  logic signed [49:0]      mprod_r;
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den_r, drem_r;
  logic [NUM_W-1:0]        dd_r, mag;
  logic [DCNT_W-1:0]       dcnt_r;
  logic                    nw_r;
  logic [DEN_W:0]          dv_t;
  logic [31:0]             len, sat;
  logic                    out_valid_r;
  out_item_t               out_r;

  assign len  = (smooth_len_r != 32'd0) ? smooth_len_r : min_len_r;
  assign mag  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign dv_t = {drem_r, dd_r[NUM_W-1]};

  // Round-to-nearest quotient, saturated to 32-bit signed
  always_comb begin
    if (nw_r) begin
      sat = '0;
    end else if (num_r[NUM_W-1]) begin
      sat = (dd_r > NUM_W'(32'h8000_0000)) ? 32'h8000_0000 : -dd_r[31:0];
    end else begin
      sat = (dd_r > NUM_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : dd_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (st_r)
        S_LOAD: begin
          if (in_valid) begin
            if (mem_we) cnt_r <= cnt_r + CNT_W'(1);
            if (in_data.final_point) begin
              n_r  <= mem_we ? cnt_r + CNT_W'(1) : cnt_r;
              h_r  <= H_W'(len) * H_W'(radius_r);
              i_r  <= '0;
              st_r <= S_RDI;
            end
          end
        end
        S_RDI: st_r <= S_LATI;
        S_LATI: begin
          xi_r  <= rd_q_r[95:64];
          yi_r  <= rd_q_r[63:32];
          j_r   <= '0;
          num_r <= '0;
          den_r <= '0;
          st_r  <= S_RDJ;
        end
        S_RDJ: st_r <= S_LATJ;
        S_LATJ: begin
          vj_r <= rd_q_r[31:0];
          st_r <= S_KWAIT;
        end
        S_KWAIT: begin
          if (kres.done) begin
            w_r  <= kres.weight;
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          mprod_r <= signed'({1'b0, w_r}) * vj_r;
          den_r   <= den_r + DEN_W'(w_r);
          st_r    <= S_ACC;
        end
        S_ACC: begin
          num_r <= num_r + {{(NUM_W-50){mprod_r[49]}}, mprod_r};
          if (j_r == last_idx) begin
            st_r <= S_DPREP;
          end else begin
            j_r  <= j_r + IDX_W'(1);
            st_r <= S_RDJ;
          end
        end
        S_DPREP: begin
          nw_r   <= (den_r == '0);
          dd_r   <= mag + NUM_W'(den_r >> 1);
          drem_r <= '0;
          dcnt_r <= '0;
          st_r   <= (den_r == '0) ? S_OUT : S_DIV;
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (dv_t >= {1'b0, den_r}) begin
            drem_r <= DEN_W'(dv_t - {1'b0, den_r});
            dd_r   <= {dd_r[NUM_W-2:0], 1'b1};
          end else begin
            drem_r <= dv_t[DEN_W-1:0];
            dd_r   <= {dd_r[NUM_W-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(NUM_W - 1)) st_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r       <= 1'b1;
            out_r.point_index <= 6'(i_r);
            out_r.smoothed    <= sat;
            out_r.no_weight   <= nw_r;
            out_r.run_end     <= (i_r == last_idx);
            if (i_r == last_idx) begin
              cnt_r <= '0;
              st_r  <= S_LOAD;
            end else begin
              i_r  <= i_r + IDX_W'(1);
              st_r <= S_RDI;
            end
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS)) else $error("point count beyond memory depth");
  a_no_weight_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_weight |-> out_data.smoothed == '0)
    else $error("no_weight result with nonzero value");
  a_out_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) && !out_valid_r |=> out_valid_r)
    else $error("result not issued");
  a_kernel_idle_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !kres.done) else $error("kernel active during load");

endmodule

/* hdl/ksm_kernel.sv */
// Pair kernel unit: distance by iterative square root, q by restoring
// division, Wendland C2 polynomial on one shared 35x18 multiplier. Uses ksm_pkg.
`timescale 1ns / 1ps

module ksm_kernel import ksm_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  kreq_t          req,
  input  logic [H_W-1:0] h,
  output kres_t          res
);

  typedef enum logic [2:0] {K_IDLE, K_SQ, K_SQRT, K_CMP, K_DIV, K_POLY, K_DONE} kst_t;

  kst_t              st_r;
  logic [2:0]        step_r;
  logic [4:0]        cnt_r;
  logic [DIFF_W-1:0] ux_r, uy_r;
  logic [65:0]       acc_r;
  logic [52:0]       prod_r;
  logic [63:0]       rad_r;
  logic [35:0]       rem_r;
  logic [31:0]       root_r;
  logic              scale_r;
  logic [48:0]       drem_r;
  logic [15:0]       q_r;
  logic [W_W-1:0]    w_r;

  logic [34:0] mul_a;
  logic [17:0] mul_b;
  logic [65:0] sq_sum;
  logic [35:0] rem_sh, trial;
  logic [32:0] dist_q;
  logic [48:0] dist_sh, dv_t, h_ext;
  logic [W_W-1:0] r_val;
  logic [17:0]    coef;

  assign r_val  = ONE_Q16 - W_W'(q_r);
  assign coef   = 18'(q_r) * 18'd3 + 18'(ONE_Q16);
  assign sq_sum = acc_r + 66'({prod_r[48:0], 17'b0});
  assign rem_sh = {rem_r[33:0], rad_r[63:62]};
  assign trial  = {2'b0, root_r, 2'b01};
  assign dist_q = scale_r ? {root_r, 1'b0} : {1'b0, root_r};
  assign dist_sh = 49'({dist_q, 8'b0});
  assign h_ext   = {1'b0, h};
  assign dv_t    = {drem_r[47:0], 1'b0};

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_r == K_SQ) begin
      case (step_r)
        3'd0: begin mul_a = 35'(ux_r); mul_b = 18'(ux_r[16:0]);  end
        3'd1: begin mul_a = 35'(ux_r); mul_b = 18'(ux_r[32:17]); end
        3'd2: begin mul_a = 35'(uy_r); mul_b = 18'(uy_r[16:0]);  end
        3'd3: begin mul_a = 35'(uy_r); mul_b = 18'(uy_r[32:17]); end
        default: ;
      endcase
    end else if (st_r == K_POLY) begin
      case (step_r)
        3'd0: begin mul_a = 35'(r_val);    mul_b = 18'(r_val); end
        3'd1: begin mul_a = prod_r[34:0];  mul_b = 18'(r_val); end
        3'd2: begin mul_a = prod_r[50:16]; mul_b = coef;       end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= K_IDLE;
      step_r <= '0;
      cnt_r  <= '0;
    end else begin
      case (st_r)
        K_IDLE: begin
          if (req.start) begin
            ux_r   <= req.ux;
            uy_r   <= req.uy;
            step_r <= '0;
            st_r   <= K_SQ;
          end
        end
        // squares from two partial products each, on the low 17 and high 16 bits
        K_SQ: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd1: acc_r <= 66'(prod_r);
            3'd2: acc_r <= sq_sum;
            3'd3: acc_r <= acc_r + 66'(prod_r);
            3'd4: begin
              scale_r <= |sq_sum[65:64];
              rad_r   <= (|sq_sum[65:64]) ? sq_sum[65:2] : sq_sum[63:0];
              rem_r   <= '0;
              root_r  <= '0;
              cnt_r   <= '0;
              st_r    <= K_SQRT;
            end
            default: ;
          endcase
        end
        // one root bit per cycle
        K_SQRT: begin
          rad_r <= {rad_r[61:0], 2'b0};
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) st_r <= K_CMP;
        end
        // q >= 1 (or zero radius) gives no weight
        K_CMP: begin
          if (dist_sh >= h_ext) begin
            w_r  <= '0;
            st_r <= K_DONE;
          end else begin
            drem_r <= dist_sh;
            q_r    <= '0;
            cnt_r  <= '0;
            st_r   <= K_DIV;
          end
        end
        K_DIV: begin
          if (dv_t >= h_ext) begin
            drem_r <= dv_t - h_ext;
            q_r    <= {q_r[14:0], 1'b1};
          end else begin
            drem_r <= dv_t;
            q_r    <= {q_r[14:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            step_r <= '0;
            st_r   <= K_POLY;
          end
        end
        // (1-q)^3 * (1+3q)
        K_POLY: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd3) begin
            w_r  <= prod_r[48:32];
            st_r <= K_DONE;
          end
        end
        K_DONE: st_r <= K_IDLE;
        default: st_r <= K_IDLE;
      endcase
    end
  end

  assign res.done   = (st_r == K_DONE);
  assign res.weight = w_r;

endmodule
